@@ sv/cmd_pkg.sv @@
// Package for the chorus: sizes, register indexes, reset values and the sine table.
`default_nettype none
package cmd_pkg;

    // Stream and store sizes
    localparam int CHANNELS      = 2;
    localparam int DELAY_LENGTH  = 2048;
    localparam int SAMPLE_BITS   = 24;
    localparam int SINE_ENTRIES  = 1024;

    localparam int AW        = $clog2(DELAY_LENGTH);
    localparam int SINE_AW   = $clog2(SINE_ENTRIES);
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = AW + FRAC_BITS;
    localparam int MAX_DELAY = (DELAY_LENGTH - 2) * 256;

    // Register widths
    localparam int PHASE_W = 32;
    localparam int DLY_W   = 19;
    localparam int WET_W   = 17;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 2;

    localparam logic [WET_W-1:0] FULL_WET = WET_W'(65536);

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CENTRE_DELAY = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SWEEP_DEPTH  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_WET_GAIN     = 2'd3;

    // Reset values
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = PHASE_W'(71582);
    localparam logic [DLY_W-1:0]   CENTRE_DELAY_RST = DLY_W'(256000);
    localparam logic [DLY_W-1:0]   SWEEP_DEPTH_RST  = DLY_W'(72000);
    localparam logic [WET_W-1:0]   WET_GAIN_RST     = WET_W'(32768);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [15:0]            sine_t;
    typedef sine_t                         sine_rom_t [SINE_ENTRIES];

    // Q15 sine, polynomial per quadrant, built at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint p;
        longint q;
        longint z;
        longint z2;
        longint t;
        longint v;
        longint s;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            p = (longint'(k) * 131072) / SINE_ENTRIES;
            q = (p >> 15) & 3;
            z = p & 32767;
            if ((q & 1) != 0) begin
                z = 32768 - z;
            end
            z2 = (z * z) >> 15;
            t  = (z2 * 2320) >> 15;
            v  = (z2 * (21024 - t)) >> 15;
            s  = (z * (51472 - v)) >> 15;
            if (s > 32767) begin
                s = 32767;
            end
            rom[k] = ((q & 2) != 0) ? 16'(-s) : 16'(s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

@@ sv/chorus_modulated_delay.sv @@
// Stereo chorus: LFO-swept fractional delay line with dry/wet mix, one shared multiplier.
//
// Each word taken on the slave side runs through the states S_DEPTH to S_OUT in order.
// No new word is taken until S_OUT passes the frame on, held up while the output word waits.
// One shared multiplier (seven products per frame) and one read port per memory set the pace.
// Reset (aresetn low, synchronous): sequencer idle, output empty, registers to defaults,
// LFO phase and write pointer to zero. The delay memories are not swept: a fill marker
// makes never-written entries read as zero, so there is no clearing pass.
`default_nettype none
module chorus_modulated_delay (
    input  wire                            aclk,
    input  wire                            aresetn,
    // slave side: [23:0] sample_left, [47:24] sample_right
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [2*cmd_pkg::SAMPLE_BITS-1:0] s_tdata,
    // master side: [23:0] mixed_left, [47:24] mixed_right
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [2*cmd_pkg::SAMPLE_BITS-1:0] m_tdata,
    // register write port
    input  wire                            cfg_wr_en,
    input  wire  [cmd_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire  [cmd_pkg::CFG_W-1:0]      cfg_wdata
);
    import cmd_pkg::*;

    localparam int MUL_A_W = SAMPLE_BITS + 1;   // sample difference
    localparam int MUL_B_W = WET_W + 1;         // gain, fraction or sine
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = SAMPLE_BITS + WET_W + 1;
    localparam int RES_W   = ACC_W - 16;
    localparam int DSUM_W  = DLY_W + 3;
    localparam int ROUND   = 32768;
    localparam int SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN = -(2 ** (SAMPLE_BITS - 1));

    // One state per use of the multiplier or memory port
    typedef enum logic [3:0] {
        S_IDLE,     // wait for a word, look up the sine
        S_DEPTH,    // depth * sine
        S_ADDR,     // delay, clamp, read position
        S_RD0,      // read both stores at i0
        S_RD1,      // read at i1, keep s0
        S_INT_L,    // f * (s1 - s0) left, write new samples
        S_INT_R,    // left delayed sample, f * (s1 - s0) right
        S_MIX_L0,   // right delayed sample, dry * (1 - wet) left
        S_MIX_L1,   // delayed * wet left
        S_MIX_R0,   // left result, dry * (1 - wet) right
        S_MIX_R1,   // delayed * wet right
        S_OUT       // right result, hand over to output register
    } state_t;

    state_t                     state_reg, state_next;
    logic [PHASE_W-1:0]         phase_step_reg, phase_step_next;
    logic [DLY_W-1:0]           centre_delay_reg, centre_delay_next;
    logic [DLY_W-1:0]           sweep_depth_reg, sweep_depth_next;
    logic [WET_W-1:0]           wet_gain_reg, wet_gain_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [AW-1:0]              wi_reg, wi_next;
    logic                       wrapped_reg, wrapped_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [2*SAMPLE_BITS-1:0]   m_tdata_reg, m_tdata_next;

    sample_t                    dry_l_reg, dry_l_next;
    sample_t                    dry_r_reg, dry_r_next;
    sine_t                      sine_reg, sine_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [AW-1:0]              i0_reg, i0_next;
    logic [FRAC_BITS-1:0]       frac_reg, frac_next;
    logic                       rvalid_reg, rvalid_next;
    sample_t                    s0_l_reg, s0_l_next;
    sample_t                    s0_r_reg, s0_r_next;
    sample_t                    del_l_reg, del_l_next;
    sample_t                    del_r_reg, del_r_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    sample_t                    out_l_reg, out_l_next;

    // Delay memories
    sample_t                    mem_l [DELAY_LENGTH];
    sample_t                    mem_r [DELAY_LENGTH];
    sample_t                    rdata_l_reg;
    sample_t                    rdata_r_reg;
    logic                       mem_re;
    logic                       mem_we;
    logic [AW-1:0]              rd_addr;

    // Datapath
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic [WET_W-1:0]           w_eff;
    logic [WET_W-1:0]           inv_w;
    logic signed [DSUM_W-1:0]   dsum;
    logic [POS_W-1:0]           d_clamp;
    logic [POS_W-1:0]           rd_pos;
    sample_t                    s1_l;
    sample_t                    s1_r;
    sample_t                    s0_sel;
    logic signed [SAMPLE_BITS+1:0] interp_sum;
    logic signed [ACC_W-1:0]    mix_total;
    sample_t                    mix_sat;

    function automatic sample_t saturate(input logic signed [RES_W-1:0] v);
        sample_t r;
        if (v > SAMPLE_MAX) begin
            r = sample_t'(SAMPLE_MAX);
        end else if (v < SAMPLE_MIN) begin
            r = sample_t'(SAMPLE_MIN);
        end else begin
            r = sample_t'(v);
        end
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Wet gain beyond unity counts as fully wet
    assign w_eff = (wet_gain_reg > FULL_WET) ? FULL_WET : wet_gain_reg;
    assign inv_w = FULL_WET - w_eff;

    // Entries not yet written since reset read as zero
    assign s1_l = rvalid_reg ? rdata_l_reg : '0;
    assign s1_r = rvalid_reg ? rdata_r_reg : '0;

    // Delay = centre + floor(depth * sine / 2^15), then clamped
    always_comb begin
        dsum = $signed({3'b000, centre_delay_reg}) + DSUM_W'($signed(prod_reg[35:15]));
        if (dsum < 0) begin
            d_clamp = '0;
        end else if (dsum > MAX_DELAY) begin
            d_clamp = POS_W'(MAX_DELAY);
        end else begin
            d_clamp = POS_W'(dsum);
        end
        rd_pos = {wi_reg, {FRAC_BITS{1'b0}}} - d_clamp;
    end

    // Interpolation add and mix rounding, shared by both channels
    assign s0_sel     = (state_reg == S_INT_R) ? s0_l_reg : s0_r_reg;
    assign interp_sum = (SAMPLE_BITS + 2)'(s0_sel)
                      + $signed(prod_reg[SAMPLE_BITS+1+FRAC_BITS:FRAC_BITS]);
    assign mix_total  = acc_reg + ACC_W'(prod_reg);
    assign mix_sat    = saturate(mix_total[ACC_W-1:16]);

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DEPTH: begin
                mul_a = MUL_A_W'($signed({1'b0, sweep_depth_reg}));
                mul_b = MUL_B_W'(sine_reg);
            end
            S_INT_L: begin
                mul_a = MUL_A_W'(s1_l) - MUL_A_W'(s0_l_reg);
                mul_b = MUL_B_W'(frac_reg);
            end
            S_INT_R: begin
                mul_a = MUL_A_W'(s1_r) - MUL_A_W'(s0_r_reg);
                mul_b = MUL_B_W'(frac_reg);
            end
            S_MIX_L0: begin
                mul_a = MUL_A_W'(dry_l_reg);
                mul_b = MUL_B_W'(inv_w);
            end
            S_MIX_L1: begin
                mul_a = MUL_A_W'(del_l_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            S_MIX_R0: begin
                mul_a = MUL_A_W'(dry_r_reg);
                mul_b = MUL_B_W'(inv_w);
            end
            S_MIX_R1: begin
                mul_a = MUL_A_W'(del_r_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Memory port control
    assign mem_re  = (state_reg == S_RD0) || (state_reg == S_RD1);
    assign mem_we  = (state_reg == S_INT_L);
    assign rd_addr = (state_reg == S_RD1) ? i0_reg + 1'b1 : i0_reg;

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        phase_step_next   = phase_step_reg;
        centre_delay_next = centre_delay_reg;
        sweep_depth_next  = sweep_depth_reg;
        wet_gain_next     = wet_gain_reg;
        phase_next        = phase_reg;
        wi_next           = wi_reg;
        wrapped_next      = wrapped_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        dry_l_next        = dry_l_reg;
        dry_r_next        = dry_r_reg;
        sine_next         = sine_reg;
        i0_next           = i0_reg;
        frac_next         = frac_reg;
        rvalid_next       = rvalid_reg;
        s0_l_next         = s0_l_reg;
        s0_r_next         = s0_r_reg;
        del_l_next        = del_l_reg;
        del_r_next        = del_r_reg;
        acc_next          = acc_reg;
        out_l_next        = out_l_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PHASE_STEP:   phase_step_next   = cfg_wdata;
                REG_CENTRE_DELAY: centre_delay_next = cfg_wdata[DLY_W-1:0];
                REG_SWEEP_DEPTH:  sweep_depth_next  = cfg_wdata[DLY_W-1:0];
                REG_WET_GAIN:     wet_gain_next     = cfg_wdata[WET_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dry_l_next = s_tdata[SAMPLE_BITS-1:0];
                    dry_r_next = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                    sine_next  = SINE_ROM[phase_reg[PHASE_W-1 -: SINE_AW]];
                    phase_next = phase_reg + phase_step_reg;
                    state_next = S_DEPTH;
                end
            end
            S_DEPTH: begin
                state_next = S_ADDR;
            end
            S_ADDR: begin
                i0_next    = rd_pos[POS_W-1:FRAC_BITS];
                frac_next  = rd_pos[FRAC_BITS-1:0];
                state_next = S_RD0;
            end
            S_RD0: begin
                rvalid_next = wrapped_reg || (rd_addr < wi_reg);
                state_next  = S_RD1;
            end
            S_RD1: begin
                rvalid_next = wrapped_reg || (rd_addr < wi_reg);
                s0_l_next   = s1_l;
                s0_r_next   = s1_r;
                state_next  = S_INT_L;
            end
            S_INT_L: begin
                wi_next      = wi_reg + 1'b1;
                wrapped_next = wrapped_reg || (wi_reg == {AW{1'b1}});
                state_next   = S_INT_R;
            end
            S_INT_R: begin
                del_l_next = interp_sum[SAMPLE_BITS-1:0];
                state_next = S_MIX_L0;
            end
            S_MIX_L0: begin
                del_r_next = interp_sum[SAMPLE_BITS-1:0];
                state_next = S_MIX_L1;
            end
            S_MIX_L1: begin
                acc_next   = ACC_W'(prod_reg) + ACC_W'(ROUND);
                state_next = S_MIX_R0;
            end
            S_MIX_R0: begin
                out_l_next = mix_sat;
                state_next = S_MIX_R1;
            end
            S_MIX_R1: begin
                acc_next   = ACC_W'(prod_reg) + ACC_W'(ROUND);
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait here while the previous word is still unclaimed
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {((CHANNELS > 1) ? mix_sat : dry_r_reg), out_l_reg};
                    state_next    = S_IDLE;
                end else begin
                    // multiplier output drops to zero from here: fold the last product in
                    acc_next = mix_total;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            phase_step_reg   <= PHASE_STEP_RST;
            centre_delay_reg <= CENTRE_DELAY_RST;
            sweep_depth_reg  <= SWEEP_DEPTH_RST;
            wet_gain_reg     <= WET_GAIN_RST;
            phase_reg        <= '0;
            wi_reg           <= '0;
            wrapped_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_step_reg   <= phase_step_next;
            centre_delay_reg <= centre_delay_next;
            sweep_depth_reg  <= sweep_depth_next;
            wet_gain_reg     <= wet_gain_next;
            phase_reg        <= phase_next;
            wi_reg           <= wi_next;
            wrapped_reg      <= wrapped_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            dry_l_reg        <= dry_l_next;
            dry_r_reg        <= dry_r_next;
            sine_reg         <= sine_next;
            prod_reg         <= prod_next;
            i0_reg           <= i0_next;
            frac_reg         <= frac_next;
            rvalid_reg       <= rvalid_next;
            s0_l_reg         <= s0_l_next;
            s0_r_reg         <= s0_r_next;
            del_l_reg        <= del_l_next;
            del_r_reg        <= del_r_next;
            acc_reg          <= acc_next;
            out_l_reg        <= out_l_next;
        end
    end

    // Delay memories: one read and one write port each, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_l[wi_reg] <= dry_l_reg;
            if (CHANNELS > 1) begin
                mem_r[wi_reg] <= dry_r_reg;
            end
        end
        if (mem_re) begin
            rdata_l_reg <= mem_l[rd_addr];
            rdata_r_reg <= mem_r[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // a taken word blocks the slave side for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("slave side still ready after a word was taken");

    // the write pointer moves on by exactly one per stored frame
    a_wi_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (wi_reg == AW'($past(wi_reg) + 1'b1)))
        else $error("write pointer did not advance by one");

    // once the stores have been filled they stay filled
    a_wrapped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        wrapped_reg |=> wrapped_reg)
        else $error("fill marker cleared without reset");

    // a new result only ever comes from the final sequencer step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("output loaded outside the final step");
`endif

endmodule
`default_nettype wire
